[rtl/core/dshot_frame_transmitter_unit_macros.svh]
// ----------------------------------------------------------------------------
// dshot frame transmitter assertion macros
// shared property wrappers, all clocked on clk and held off during rst
// ----------------------------------------------------------------------------
`ifndef DSHOT_FRAME_TRANSMITTER_UNIT_MACROS_SVH
`define DSHOT_FRAME_TRANSMITTER_UNIT_MACROS_SVH

// same-cycle implication
`define DSHOT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DSHOT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/dshot_tx_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dshot_tx_pkg
// shared types, constants and word/timing functions of the dshot transmitter
// ----------------------------------------------------------------------------
package dshot_tx_pkg;

  localparam int MOTORS      = 4;
  localparam int FRAME_SLOTS = 18;
  localparam int DATA_SLOTS  = 16;
  localparam int WORD_W      = 16;
  localparam int THR_W       = 12;
  localparam int SLOT_W      = 5;
  localparam int TICK_W      = 6;
  localparam int CMD_DEPTH   = 2;
  localparam int RES_DEPTH   = 2;

  localparam logic [THR_W-1:0] THR_MIN  = 12'd48;
  localparam logic [THR_W-1:0] THR_MAX  = 12'd2047;
  localparam logic [3:0]       CSUM_MSK = 4'h0F;

  // rate register codes
  localparam logic [1:0] RATE_300  = 2'd0;
  localparam logic [1:0] RATE_600  = 2'd1;
  localparam logic [1:0] RATE_1200 = 2'd2;

  // request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  typedef logic [WORD_W-1:0] word_t;

  // classified item between front and back
  typedef struct packed {
    logic                          tick;
    logic [MOTORS-1:0][WORD_W-1:0] words;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic [MOTORS-1:0] pins;
    logic              accepted;
    logic              sending;
  } res_t;

  // clamp, shift in telemetry bit 0, append nibble checksum
  function automatic word_t build_word(input logic [THR_W-1:0] raw);
    logic [THR_W-1:0] v;
    logic [11:0]      payload;
    logic [3:0]       sum;
    if (raw < THR_MIN) begin
      v = '0;
    end else if (raw > THR_MAX) begin
      v = THR_MAX;
    end else begin
      v = raw;
    end
    payload = {v[10:0], 1'b0};
    sum     = (payload[3:0] ^ payload[7:4] ^ payload[11:8]) & CSUM_MSK;
    return {payload, sum};
  endfunction

  // slot length in ticks
  function automatic logic [TICK_W-1:0] slot_period(input logic [1:0] rate);
    case (rate)
      RATE_600:  return 6'd20;
      RATE_1200: return 6'd10;
      default:   return 6'd40;
    endcase
  endfunction

  // high time for a one bit, 3/4 of the slot rounded
  function automatic logic [TICK_W-1:0] high_one(input logic [1:0] rate);
    case (rate)
      RATE_600:  return 6'd15;
      RATE_1200: return 6'd8;
      default:   return 6'd30;
    endcase
  endfunction

  // high time for a zero bit, 3/8 of the slot rounded
  function automatic logic [TICK_W-1:0] high_zero(input logic [1:0] rate);
    case (rate)
      RATE_600:  return 6'd8;
      RATE_1200: return 6'd4;
      default:   return 6'd15;
    endcase
  endfunction

endpackage

[rtl/core/dshot_tx_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dshot_tx_front
// classifies an incoming item and encodes the four throttles into dshot words
// ----------------------------------------------------------------------------
module dshot_tx_front (
  input  logic                       req_type,
  input  logic [dshot_tx_pkg::THR_W-1:0] throttle_a,
  input  logic [dshot_tx_pkg::THR_W-1:0] throttle_b,
  input  logic [dshot_tx_pkg::THR_W-1:0] throttle_c,
  input  logic [dshot_tx_pkg::THR_W-1:0] throttle_d,
  output dshot_tx_pkg::cmd_t         cmd
);
  import dshot_tx_pkg::*;

  // every item carries the encoded words; only write items use them
  always_comb begin
    cmd.tick     = (req_type == REQ_TICK);
    cmd.words[0] = build_word(throttle_a);
    cmd.words[1] = build_word(throttle_b);
    cmd.words[2] = build_word(throttle_c);
    cmd.words[3] = build_word(throttle_d);
  end

endmodule

[rtl/core/dshot_tx_cmd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dshot_tx_cmd_queue
// short queue of classified items between front and back
// ----------------------------------------------------------------------------
module dshot_tx_cmd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  dshot_tx_pkg::cmd_t wr_cmd,
  output logic               avail,
  input  logic               take,
  output dshot_tx_pkg::cmd_t rd_cmd
);
  import dshot_tx_pkg::*;

  localparam int PTR_W = $clog2(CMD_DEPTH);

  cmd_t               slots [CMD_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     count;
  logic               do_wr;
  logic               do_rd;

  assign full   = (count == (PTR_W+1)'(CMD_DEPTH));
  assign avail  = (count != '0);
  assign do_wr  = push && !full;
  assign do_rd  = take && avail;
  assign rd_cmd = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/core/dshot_tx_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dshot_tx_back
// frame engine: loads words, steps slot timing per tick, queues result items
// ----------------------------------------------------------------------------
`include "dshot_frame_transmitter_unit_macros.svh"

module dshot_tx_back (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         rate,
  input  logic               avail,
  output logic               take,
  input  dshot_tx_pkg::cmd_t cmd,
  output logic               empty,
  input  logic               pop,
  output dshot_tx_pkg::res_t res
);
  import dshot_tx_pkg::*;

  localparam int PTR_W = $clog2(RES_DEPTH);

  // frame state
  logic [MOTORS-1:0][WORD_W-1:0] words;
  logic [SLOT_W-1:0]             slot_index;
  logic [TICK_W-1:0]             tick_in_slot;
  logic                          busy;

  logic [MOTORS-1:0][WORD_W-1:0] words_next;
  logic [SLOT_W-1:0]             slot_index_next;
  logic [TICK_W-1:0]             tick_in_slot_next;
  logic                          busy_next;
  res_t                          res_new;

  // result queue
  res_t                          res_slots [RES_DEPTH];
  logic [PTR_W-1:0]              wr_ptr;
  logic [PTR_W-1:0]              rd_ptr;
  logic [PTR_W:0]                res_count;
  logic                          res_full;
  logic                          do_pop;

  logic [TICK_W-1:0]             period;
  logic [TICK_W-1:0]             tick_inc;
  logic [3:0]                    bit_sel;

  assign res_full = (res_count == (PTR_W+1)'(RES_DEPTH));
  assign empty    = (res_count == '0);
  assign do_pop   = pop && !empty;
  assign take     = avail && !res_full;
  assign res      = res_slots[rd_ptr];

  assign period   = slot_period(rate);
  assign tick_inc = tick_in_slot + 1'b1;
  assign bit_sel  = 4'(DATA_SLOTS - 1) - slot_index[3:0];

  // next frame state and result for the item at the head of the queue
  always_comb begin
    words_next        = words;
    slot_index_next   = slot_index;
    tick_in_slot_next = tick_in_slot;
    busy_next         = busy;
    res_new           = '0;
    if (!cmd.tick) begin
      if (!busy) begin
        words_next        = cmd.words;
        slot_index_next   = '0;
        tick_in_slot_next = '0;
        busy_next         = 1'b1;
        res_new.accepted  = 1'b1;
      end
    end else if (busy) begin
      if (slot_index < SLOT_W'(DATA_SLOTS)) begin
        for (int m = 0; m < MOTORS; m++) begin
          res_new.pins[m] = words[m][bit_sel] ? (tick_in_slot < high_one(rate))
                                              : (tick_in_slot < high_zero(rate));
        end
      end
      if (tick_inc >= period) begin
        tick_in_slot_next = '0;
        if (slot_index + 1'b1 >= SLOT_W'(FRAME_SLOTS)) begin
          slot_index_next = '0;
          busy_next       = 1'b0;
        end else begin
          slot_index_next = slot_index + 1'b1;
        end
      end else begin
        tick_in_slot_next = tick_inc;
      end
    end
    res_new.sending = busy_next;
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      words        <= '0;
      slot_index   <= '0;
      tick_in_slot <= '0;
      busy         <= 1'b0;
    end else if (take) begin
      words        <= words_next;
      slot_index   <= slot_index_next;
      tick_in_slot <= tick_in_slot_next;
      busy         <= busy_next;
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    if (take) begin
      res_slots[wr_ptr] <= res_new;
    end
  end

  // result pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      res_count <= '0;
    end else begin
      if (take) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({take, do_pop})
        2'b10:   res_count <= res_count + 1'b1;
        2'b01:   res_count <= res_count - 1'b1;
        default: res_count <= res_count;
      endcase
    end
  end

  // checks
  `DSHOT_ASSERT_NOW(a_idle_counters_clear, !busy, (slot_index == '0) && (tick_in_slot == '0), "idle with nonzero slot counters")
  `DSHOT_ASSERT_NOW(a_slot_in_frame, 1'b1, slot_index < SLOT_W'(FRAME_SLOTS), "slot index past frame end")
  `DSHOT_ASSERT_NEXT(a_busy_write_ignored, take && !cmd.tick && busy, $stable(words) && busy, "write during frame changed words")
  `DSHOT_ASSERT_NOW(a_no_take_when_full, res_full && !pop, !take, "item taken with result queue full")

endmodule

[rtl/core/dshot_frame_transmitter_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dshot_frame_transmitter_unit
// four-channel dshot frame transmitter with queue-style item ports
// ----------------------------------------------------------------------------
// One item is taken per clock while the result queue has room, and each item
// gives exactly one result item. A write item (req_type 0) loads four clamped,
// checksummed 16-bit words and starts a frame unless one is in flight; a tick
// item (req_type 1) advances the frame by one timer count and reports the pin
// levels for that count. Items pass a two-entry command queue into the frame
// engine, which handles one item per cycle and writes its result into a
// two-entry result queue, so a result shows in the cycle after its item is
// taken and a sustained rate of one item per clock holds as long as pop keeps
// up. The rate register at address 0 sets the slot length (40, 20 or 10 ticks).
// ----------------------------------------------------------------------------
module dshot_frame_transmitter_unit (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [1:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  // items in
  input  logic                           push,
  output logic                           full,
  input  logic                           req_type,
  input  logic [dshot_tx_pkg::THR_W-1:0] throttle_a,
  input  logic [dshot_tx_pkg::THR_W-1:0] throttle_b,
  input  logic [dshot_tx_pkg::THR_W-1:0] throttle_c,
  input  logic [dshot_tx_pkg::THR_W-1:0] throttle_d,
  // items out
  output logic                           empty,
  input  logic                           pop,
  output logic                           pin_a,
  output logic                           pin_b,
  output logic                           pin_c,
  output logic                           pin_d,
  output logic                           accepted,
  output logic                           sending
);
  import dshot_tx_pkg::*;

  logic [1:0] protocol_rate;
  cmd_t       front_cmd;
  cmd_t       head_cmd;
  logic       head_avail;
  logic       head_take;
  res_t       res;

  // rate register, single register so every address maps to it
  assign pready = 1'b1;
  assign prdata = {30'd0, protocol_rate} | {30'd0, paddr & 2'b00};

  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_rate <= RATE_300;
    end else if (psel && penable && pwrite && pready) begin
      protocol_rate <= pwdata[1:0];
    end
  end

  // encode
  dshot_tx_front u_front (
    .req_type   (req_type),
    .throttle_a (throttle_a),
    .throttle_b (throttle_b),
    .throttle_c (throttle_c),
    .throttle_d (throttle_d),
    .cmd        (front_cmd)
  );

  // decoupling queue
  dshot_tx_cmd_queue u_cmd_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .wr_cmd (front_cmd),
    .avail  (head_avail),
    .take   (head_take),
    .rd_cmd (head_cmd)
  );

  // frame engine and result queue
  dshot_tx_back u_back (
    .clk   (clk),
    .rst   (rst),
    .rate  (protocol_rate),
    .avail (head_avail),
    .take  (head_take),
    .cmd   (head_cmd),
    .empty (empty),
    .pop   (pop),
    .res   (res)
  );

  // result fields
  assign pin_a    = res.pins[0];
  assign pin_b    = res.pins[1];
  assign pin_c    = res.pins[2];
  assign pin_d    = res.pins[3];
  assign accepted = res.accepted;
  assign sending  = res.sending;

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the dshot frame transmitter against a cycle-free frame predictor
// ----------------------------------------------------------------------------
// Every accepted item is run through a behavioral copy of the frame engine
// (clamping, checksum, slot timing, frame end). The predicted pin levels and
// flags are queued and matched in order against each popped result item.
// The rate register is written and read back between phases, including the
// unused code, and some phases start while a frame is still in flight.
// Both the push and pop sides idle at random in several phases.
// ----------------------------------------------------------------------------
module testbench;
  import dshot_tx_pkg::*;

  localparam int CLK_HALF    = 2;
  localparam int STALL_LIMIT = 1000;
  localparam int PHASE_ITEMS = 120;
  localparam int MAX_SHOWN   = 10;

  typedef struct packed {
    logic                         req;
    logic [MOTORS-1:0][THR_W-1:0] thr;
  } req_item_t;

  // dut ports
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [1:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              push = 1'b0;
  logic              full;
  logic              req_type = REQ_WRITE;
  logic [THR_W-1:0]  throttle_a = '0;
  logic [THR_W-1:0]  throttle_b = '0;
  logic [THR_W-1:0]  throttle_c = '0;
  logic [THR_W-1:0]  throttle_d = '0;
  logic              empty;
  logic              pop = 1'b0;
  logic              pin_a;
  logic              pin_b;
  logic              pin_c;
  logic              pin_d;
  logic              accepted;
  logic              sending;

  // frame predictor state
  logic [1:0]        cur_rate;
  logic [WORD_W-1:0] frame_word [MOTORS];
  int                slot_pos;
  int                tick_pos;
  logic              frame_busy;

  res_t              expected_levels[$];
  int                mismatch_count = 0;
  int                send_idle_pct  = 0;
  int                pop_stall_pct  = 0;
  int                quiet_cycles   = 0;

  dshot_frame_transmitter_unit dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .push       (push),
    .full       (full),
    .req_type   (req_type),
    .throttle_a (throttle_a),
    .throttle_b (throttle_b),
    .throttle_c (throttle_c),
    .throttle_d (throttle_d),
    .empty      (empty),
    .pop        (pop),
    .pin_a      (pin_a),
    .pin_b      (pin_b),
    .pin_c      (pin_c),
    .pin_d      (pin_d),
    .accepted   (accepted),
    .sending    (sending)
  );

  // clock
  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  // clamp to the dshot range, telemetry bit 0, nibble xor checksum
  function automatic logic [WORD_W-1:0] encode_throttle(input logic [THR_W-1:0] raw);
    logic [11:0] v;
    logic [11:0] payload;
    logic [11:0] csum;
    v = raw;
    if (v < 12'd48) begin
      v = 12'd0;
    end else if (v > 12'd2047) begin
      v = 12'd2047;
    end
    payload = v << 1;
    csum    = (payload ^ (payload >> 4) ^ (payload >> 8)) & 12'h00F;
    return {payload, csum[3:0]};
  endfunction

  // advance the frame predictor by one item and give its result
  function automatic res_t predict_levels(input req_item_t it);
    res_t r;
    int   p;
    int   hi1;
    int   hi0;
    logic b;
    r = '0;
    if (it.req == REQ_WRITE) begin
      if (!frame_busy) begin
        for (int m = 0; m < MOTORS; m++) frame_word[m] = encode_throttle(it.thr[m]);
        slot_pos   = 0;
        tick_pos   = 0;
        frame_busy = 1'b1;
        r.accepted = 1'b1;
      end
    end else if (frame_busy) begin
      p = (cur_rate == RATE_1200) ? 10 : (cur_rate == RATE_600) ? 20 : 40;
      if (slot_pos < DATA_SLOTS) begin
        hi1 = (3 * p + 2) / 4;
        hi0 = (3 * p + 4) / 8;
        for (int m = 0; m < MOTORS; m++) begin
          b = frame_word[m][DATA_SLOTS - 1 - slot_pos];
          r.pins[m] = (tick_pos < (b ? hi1 : hi0));
        end
      end
      tick_pos++;
      if (tick_pos >= p) begin
        tick_pos = 0;
        slot_pos++;
        if (slot_pos >= FRAME_SLOTS) begin
          slot_pos   = 0;
          frame_busy = 1'b0;
        end
      end
    end
    r.sending = frame_busy;
    return r;
  endfunction

  // throttle values weighted toward the clamp edges
  function automatic logic [THR_W-1:0] pick_throttle();
    case ($urandom_range(7))
      0:       return 12'd0;
      1:       return 12'd47;
      2:       return 12'd48;
      3:       return 12'd2047;
      4:       return 12'd2048;
      5:       return 12'd4095;
      default: return 12'($urandom_range(4095));
    endcase
  endfunction

  // send one item, predict its result at the accepting edge
  task automatic send_item(input req_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push       <= 1'b1;
    req_type   <= it.req;
    throttle_a <= it.thr[0];
    throttle_b <= it.thr[1];
    throttle_c <= it.thr[2];
    throttle_d <= it.thr[3];
    @(posedge clk);
    while (full) @(posedge clk);
    expected_levels.push_back(predict_levels(it));
  endtask

  // stop pushing and wait until every result item has been popped
  task automatic wait_results_drained();
    push <= 1'b0;
    @(posedge clk);
    while (expected_levels.size() != 0) @(posedge clk);
  endtask

  // apb write of the rate register
  task automatic write_rate_reg(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 2'd0;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    cur_rate = value[1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // apb read of the rate register, compared with the predicted value
  task automatic read_rate_back();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= 2'd0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {30'd0, cur_rate}) begin
      mismatch_count++;
      if (mismatch_count <= MAX_SHOWN) begin
        $display("rate readback: expected %0d got %0h", cur_rate, prdata);
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // write a rate with random upper bits and read it back
  task automatic set_rate(input logic [1:0] rate);
    write_rate_reg({$urandom_range(1) ? 30'($urandom()) : 30'd0, rate});
    read_rate_back();
  endtask

  task automatic build_item(output req_item_t it, input logic req);
    it.req = req;
    for (int m = 0; m < MOTORS; m++) it.thr[m] = pick_throttle();
  endtask

  // reset value readback, then every rate code
  task automatic test_rate_register();
    read_rate_back();
    set_rate(RATE_600);
    set_rate(2'd3);
    set_rate(RATE_1200);
    set_rate(RATE_300);
  endtask

  // tick while idle, clamp edges, write while busy, unused rate mid-frame
  task automatic test_directed_cases();
    req_item_t it;
    it = '0;
    it.req = REQ_TICK;
    send_item(it);
    it.req = REQ_WRITE;
    it.thr = {12'd2047, 12'd48, 12'd47, 12'd0};
    send_item(it);
    it.thr = {12'd1, 12'd4094, 12'd4095, 12'd2048};
    send_item(it);
    it.req = REQ_TICK;
    repeat (5) send_item(it);
    wait_results_drained();
    set_rate(2'd3);
    repeat (5) send_item(it);
    wait_results_drained();
    set_rate(RATE_1200);
    repeat (5) send_item(it);
    it.req = REQ_WRITE;
    it.thr = {12'd4095, 12'd4095, 12'd4095, 12'd4095};
    send_item(it);
    wait_results_drained();
  endtask

  // mostly whole frames with random words, some stray writes and idle ticks
  task automatic test_random_traffic();
    logic [1:0] phase_rate [8];
    req_item_t  it;
    logic       req;
    phase_rate = '{RATE_1200, RATE_600, RATE_1200, RATE_300,
                   RATE_1200, 2'd3, RATE_600, RATE_1200};
    for (int ph = 0; ph < 8; ph++) begin
      // the rate may change while a frame is still in flight
      set_rate(phase_rate[ph]);
      case (ph % 4)
        0:       begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        1:       begin send_idle_pct = 50; pop_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  pop_stall_pct = 50; end
        default: begin send_idle_pct = 33; pop_stall_pct = 33; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (!frame_busy) begin
          req = ($urandom_range(9) == 0) ? REQ_TICK : REQ_WRITE;
        end else begin
          req = ($urandom_range(99) < 3) ? REQ_WRITE : REQ_TICK;
        end
        build_item(it, req);
        send_item(it);
      end
      wait_results_drained();
    end
    send_idle_pct = 0;
    pop_stall_pct = 0;
  endtask

  // result checker and pop driver
  always @(posedge clk) begin
    res_t exp_r;
    if (!rst && pop && !empty) begin
      if (expected_levels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN) begin
          $display("result item with nothing expected: pins %b%b%b%b acc %b snd %b",
                   pin_d, pin_c, pin_b, pin_a, accepted, sending);
        end
      end else begin
        exp_r = expected_levels.pop_front();
        if (pin_a !== exp_r.pins[0] || pin_b !== exp_r.pins[1] ||
            pin_c !== exp_r.pins[2] || pin_d !== exp_r.pins[3] ||
            accepted !== exp_r.accepted || sending !== exp_r.sending) begin
          mismatch_count++;
          if (mismatch_count <= MAX_SHOWN) begin
            $display({"result mismatch: pins d..a exp %b got %b%b%b%b, ",
                      "acc exp %b got %b, snd exp %b got %b"},
                     exp_r.pins, pin_d, pin_c, pin_b, pin_a,
                     exp_r.accepted, accepted, exp_r.sending, sending);
          end
        end
      end
    end
    pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    cur_rate   = RATE_300;
    slot_pos   = 0;
    tick_pos   = 0;
    frame_busy = 1'b0;
    for (int m = 0; m < MOTORS; m++) frame_word[m] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_rate_register();
    test_directed_cases();
    test_random_traffic();
    wait_results_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/dshot_tx_pkg.sv
rtl/core/dshot_tx_front.sv
rtl/core/dshot_tx_cmd_queue.sv
rtl/core/dshot_tx_back.sv
rtl/core/dshot_frame_transmitter_unit.sv
dv/testbench.sv
